[design/rsd_pkg.sv]
// Package for the radial stick deadzone: widths of the pipeline fields.
`default_nettype none
package rsd_pkg;
  localparam int unsigned FRAC_BITS = 14;   // 1.0 = 2^FRAC_BITS
  localparam int unsigned AxisW = 16;
  localparam int unsigned DzW   = 14;
  localparam int unsigned SqW   = 30;   // x*x + y*y <= 2^29
  localparam int unsigned MagW  = 15;   // floor sqrt <= 23170
  localparam int unsigned NW    = 15;   // n in 0..16384
  localparam int unsigned NumW  = 29;   // (mag - dz) << 14
  localparam int unsigned DenW  = 15;   // 1.0 - dz, 1..16384
  localparam int unsigned ProdW = 31;   // |axis| * n <= 2^28, with sign
  localparam int unsigned QW    = 15;   // |out| <= 16384
endpackage
`default_nettype wire

[design/rsd_isqrt.sv]
// Pipelined floor square root, one result bit per stage.
`default_nettype none
module rsd_isqrt import rsd_pkg::*; #(
  parameter int unsigned SideW = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic [SqW-1:0]   sq,
  input  wire logic [SideW-1:0] side_in,
  output logic [MagW-1:0]       mag,
  output logic [SideW-1:0]      side_out
);
  logic [SqW-1:0]   rem  [MagW+1];
  logic [MagW-1:0]  root [MagW+1];
  logic [SideW-1:0] side [MagW+1];

  always_comb begin
    rem[0]  = sq;
    root[0] = '0;
    side[0] = side_in;
  end

  for (genvar s = 0; s < MagW; s++) begin : g_st
    localparam int unsigned B = MagW - 1 - s;
    logic [SqW+1:0] trial;
    logic [MagW-1:0] cand;
    always_comb begin
      cand  = root[s] | (MagW'(1) << B);
      trial = (SqW+2)'(cand) * (SqW+2)'(cand);
    end
    always_ff @(posedge clk) begin
      if (rst) side[s+1] <= '0;
      else if (en) side[s+1] <= side[s];
      if (en) begin
        rem[s+1]  <= rem[s];
        if (trial <= (SqW+2)'(rem[s])) root[s+1] <= cand;
        else root[s+1] <= root[s];
      end
    end
  end

  assign mag      = root[MagW];
  assign side_out = side[MagW];
endmodule
`default_nettype wire

[design/rsd_div.sv]
// Pipelined restoring divider, unsigned, one quotient bit per stage.
`default_nettype none
module rsd_div import rsd_pkg::*; #(
  parameter int unsigned NumBits = 29,
  parameter int unsigned DenBits = 15,
  parameter int unsigned QBits   = 15,
  parameter int unsigned SideW   = 2
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic [NumBits-1:0] num,
  input  wire logic [DenBits-1:0] den,
  input  wire logic [SideW-1:0]   side_in,
  output logic [QBits-1:0]        quo,
  output logic [SideW-1:0]        side_out
);
  // quotient known to fit QBits; remainder kept below den
  logic [NumBits-1:0] nr  [QBits+1];
  logic [DenBits-1:0] dv  [QBits+1];
  logic [QBits-1:0]   q   [QBits+1];
  logic [DenBits:0]   rm  [QBits+1];
  logic [SideW-1:0]   sd  [QBits+1];

  always_comb begin
    nr[0] = num; dv[0] = den; q[0] = '0; sd[0] = side_in;
    rm[0] = (DenBits+1)'(num >> QBits);
  end

  for (genvar s = 0; s < QBits; s++) begin : g_st
    localparam int unsigned B = QBits - 1 - s;
    logic [DenBits+1:0] sh;
    logic [DenBits+1:0] df;
    always_comb begin
      sh = {rm[s], nr[s][B]};
      df = sh - (DenBits+2)'(dv[s]);
    end
    always_ff @(posedge clk) begin
      if (rst) sd[s+1] <= '0;
      else if (en) sd[s+1] <= sd[s];
      if (en) begin
        nr[s+1] <= nr[s]; dv[s+1] <= dv[s];
        if (!df[DenBits+1]) begin
          rm[s+1] <= df[DenBits:0];
          q[s+1]  <= q[s] | (QBits'(1) << B);
        end else begin
          rm[s+1] <= sh[DenBits:0];
          q[s+1]  <= q[s];
        end
      end
    end
  end

  assign quo      = q[QBits];
  assign side_out = sd[QBits];
endmodule
`default_nettype wire

[design/radial_stick_deadzone.sv]
// Top level of the radial stick deadzone: clamp, magnitude, rescale, scale axes.
// One sample per cycle unless stalled. Stages: 2 (clamp, squares), 15 (root), 1,
// 29 (normalize), 1, 15 (axis scale), 1 (output). Every stage is a register
// row that advances whenever the output register can take data; a stall freezes the
// whole pipeline, so nothing is lost or repeated. The 14-bit deadzone stays below
// 1.0, so the normalizing divisor is never zero. Deadzone writes are taken at any
// time and apply to samples already in flight, so write only while idle.
`default_nettype none
module radial_stick_deadzone import rsd_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [DzW-1:0]    deadzone,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic signed [AxisW-1:0] raw_x,
  input  wire logic signed [AxisW-1:0] raw_y,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic signed [AxisW-1:0] out_x,
  output logic signed [AxisW-1:0] out_y
);
  localparam logic signed [AxisW-1:0] One = AxisW'(1) << FRAC_BITS;
  localparam int unsigned SW = 2 + 2*AxisW + MagW; // valid, zero, x, y, mag

  logic [DzW-1:0] dz;
  logic en;
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) dz <= DzW'(4096);
    else if (cfg_valid) dz <= deadzone;
  end

  // stage 1: clamp
  logic v1;
  logic signed [AxisW-1:0] x1, y1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
    if (en) begin
      x1 <= (raw_x > One) ? One : (raw_x < -One) ? -One : raw_x;
      y1 <= (raw_y > One) ? One : (raw_y < -One) ? -One : raw_y;
    end
  end

  // stage 2: squares
  logic v2;
  logic signed [AxisW-1:0] x2, y2;
  logic [SqW-1:0] sq2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
    if (en) begin
      x2 <= x1; y2 <= y1;
      sq2 <= SqW'(32'(x1 * x1)) + SqW'(32'(y1 * y1));
    end
  end

  // magnitude
  logic [MagW-1:0] mag3;
  logic [1+2*AxisW-1:0] s3;
  rsd_isqrt #(.SideW(1+2*AxisW)) u_sqrt (
    .clk, .rst, .en, .sq(sq2), .side_in({v2, x2, y2}), .mag(mag3), .side_out(s3)
  );
  logic v3;
  assign v3 = s3[2*AxisW];

  // stage 4: numerator and denominator of the normalized radius
  logic [SW-1:0] side4;
  logic [NumW-1:0] num4;
  logic [DenW-1:0] den4;
  always_ff @(posedge clk) begin
    if (rst) side4 <= '0;
    else if (en) side4 <= {v3, (mag3 < MagW'(dz)) || (mag3 == '0),
                           s3[2*AxisW-1:0], mag3};
    if (en) begin
      num4  <= (mag3 >= MagW'(dz)) ? NumW'(mag3 - MagW'(dz)) << FRAC_BITS : '0;
      den4  <= DenW'(One) - DenW'(dz);
    end
  end

  logic [NumW-1:0] nq5;
  logic [SW-1:0] side5;
  rsd_div #(.NumBits(NumW), .DenBits(DenW), .QBits(NumW), .SideW(SW)) u_ndiv (
    .clk, .rst, .en, .num(num4), .den(den4), .side_in(side4), .quo(nq5),
    .side_out(side5)
  );

  // stage 6: clamp n and form |axis| * n
  logic [SW-1:0] side6;
  logic [NumW-1:0] px6, py6;
  logic [NW-1:0] n5;
  logic [AxisW-1:0] ax5, ay5;
  logic signed [AxisW-1:0] x5, y5;
  always_comb begin
    x5  = side5[MagW+2*AxisW-1 -: AxisW];
    y5  = side5[MagW+AxisW-1 -: AxisW];
    n5  = (nq5 > NumW'(One)) ? NW'(One) : NW'(nq5);
    ax5 = x5[AxisW-1] ? -x5 : x5;
    ay5 = y5[AxisW-1] ? -y5 : y5;
  end
  always_ff @(posedge clk) begin
    if (rst) side6 <= '0;
    else if (en) side6 <= side5;
    if (en) begin
      px6 <= NumW'(32'(ax5) * 32'(n5));
      py6 <= NumW'(32'(ay5) * 32'(n5));
    end
  end

  logic [MagW-1:0] mag6;
  assign mag6 = side6[MagW-1:0];
  logic [QW-1:0] qx7, qy7;
  logic [SW-1:0] side7;
  logic v7y;
  rsd_div #(.NumBits(NumW), .DenBits(MagW), .QBits(QW), .SideW(SW)) u_xdiv (
    .clk, .rst, .en, .num(px6), .den(mag6 == '0 ? MagW'(1) : mag6), .side_in(side6),
    .quo(qx7), .side_out(side7)
  );
  // y lane carries only its valid bit, kept for the lane check
  rsd_div #(.NumBits(NumW), .DenBits(MagW), .QBits(QW), .SideW(1)) u_ydiv (
    .clk, .rst, .en, .num(py6), .den(mag6 == '0 ? MagW'(1) : mag6),
    .side_in(side6[SW-1]), .quo(qy7), .side_out(v7y)
  );

  // output register: restore signs, zero inside the deadzone
  logic v7, z7, sx7, sy7;
  always_comb begin
    v7  = side7[SW-1];
    z7  = side7[SW-2];
    sx7 = side7[MagW+2*AxisW-1];
    sy7 = side7[MagW+AxisW-1];
  end
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= v7;
    if (en) begin
      out_x <= z7 ? '0 : sx7 ? -AxisW'(qx7) : AxisW'(qx7);
      out_y <= z7 ? '0 : sy7 ? -AxisW'(qy7) : AxisW'(qy7);
    end
  end

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_x <= One && out_x >= -One && out_y <= One && out_y >= -One))
    else $error("output beyond 1.0");
  a_lanes: assert property (@(posedge clk) disable iff (rst) v7 == v7y)
    else $error("axis dividers out of step");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_x) && $stable(out_y)))
    else $error("stalled result changed");
endmodule
`default_nettype wire
